### src/slrf_pkg.sv
// Shared types, widths and codes for the line-fit unit.
package slrf_pkg;

    // Sample and set-size limits, output width and fraction width.
    localparam int SAMPLE_W    = 16;
    localparam int MAX_SAMPLES = 4096;
    localparam int OUT_W       = 48;
    localparam int FRAC_W      = 16;

    // Derived widths of the running sums.
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int PROD1_W = 2 * SAMPLE_W;
    localparam int SQ_W    = PROD1_W + CNT_W;

    // Derived widths of the cross-product engine.
    localparam int ACC_W  = SUM_W + SQ_W;
    localparam int A_LO_W = (SQ_W + 1) / 2;
    localparam int A_HI_W = SQ_W - A_LO_W;
    localparam int HALF_W = A_LO_W + 1;
    localparam int PROD_W = SUM_W + HALF_W;

    // Derived widths of the divider.
    localparam int DVD_W     = ACC_W + FRAC_W;
    localparam int Q_W       = OUT_W + 1;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // Product sequence: two partial products per term.
    localparam int NUM_TERMS = 6;
    localparam int TERM_W    = 3;
    localparam int STEP_W    = TERM_W + 1;
    localparam int NUM_STEPS = 2 * NUM_TERMS;

    // Term codes; odd terms are subtracted.
    localparam logic [TERM_W-1:0] TERM_N_SXX  = 3'd0;
    localparam logic [TERM_W-1:0] TERM_SX_SX  = 3'd1;
    localparam logic [TERM_W-1:0] TERM_N_SXY  = 3'd2;
    localparam logic [TERM_W-1:0] TERM_SX_SY  = 3'd3;
    localparam logic [TERM_W-1:0] TERM_SY_SXX = 3'd4;
    localparam logic [TERM_W-1:0] TERM_SX_SXY = 3'd5;

    // Destination codes for finished term pairs.
    localparam int DEST_W = 2;
    localparam logic [DEST_W-1:0] DEST_DEN   = 2'd0;
    localparam logic [DEST_W-1:0] DEST_NUM_S = 2'd1;
    localparam logic [DEST_W-1:0] DEST_NUM_I = 2'd2;

    // Fit status codes.
    localparam logic [1:0] FIT_OK        = 2'd0;
    localparam logic [1:0] FIT_NO_SPREAD = 2'd1;
    localparam logic [1:0] FIT_DROPPED   = 2'd2;
    localparam logic [1:0] FIT_SATURATED = 2'd3;

    // Output limits.
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_value;
        logic signed [SAMPLE_W-1:0] y_value;
        logic                       last_sample;
    } t_sample_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] intercept;
        logic [1:0]              fit_status;
    } t_fit_req;

    typedef struct packed {
        logic              sample_accept;
        logic              mac_valid;
        logic [STEP_W-1:0] mac_step;
        logic              div_start;
        logic              div_icpt;
        logic              load_result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic den_zero;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

### src/simple_linear_regression_fit_unit.sv
// Top level of the streaming least-squares line-fit unit.
//
// Sample requests (x, y) are taken one per cycle and folded into exact sums of n, x, y,
// x*x and x*y; requests beyond 4096 in a set are discarded and flagged. The request
// marked last is folded in, then the input stalls while the fit runs: the six product
// terms, each in two halves, on one shared multiplier, a drain state, and two divisions
// in a shared bit-serial divider that retires one quotient bit per cycle over a 90-bit
// dividend. A set with no x spread skips the divisions. The result sits in an output
// register, and sample intake resumes as soon as it is loaded there. Slope and
// intercept are signed Q32.16, truncated toward zero and clamped to 48 bits.
module simple_linear_regression_fit_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_sample_valid,
    input  slrf_pkg::t_sample_req   i_sample,
    output logic                    o_sample_stall,
    output logic                    o_fit_valid,
    output slrf_pkg::t_fit_req      o_fit,
    input  logic                    i_fit_stall
);

    slrf_pkg::t_ctrl_cmd    cmd;
    slrf_pkg::t_dp_status   status;

    // Sequencer.
    slrf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_last         (i_sample.last_sample),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_sample_stall (o_sample_stall)
    );

    // Sums, products, divider and result register.
    slrf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (i_sample),
        .i_fit_stall (i_fit_stall),
        .o_status    (status),
        .o_fit_valid (o_fit_valid),
        .o_fit       (o_fit)
    );

endmodule

### src/slrf_div.sv
// Bit-serial signed divider producing a saturated Q32.16 quotient.
module slrf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [slrf_pkg::ACC_W-1:0]   i_num,
    input  logic signed [slrf_pkg::ACC_W-1:0]   i_den,
    output logic                                o_done,
    output logic [slrf_pkg::OUT_W-1:0]          o_quot,
    output logic                                o_sat
);

    logic                               r_busy;
    logic                               r_fin;
    logic [slrf_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [slrf_pkg::DVD_W-1:0]         r_dvd;
    logic [slrf_pkg::ACC_W-1:0]         r_dm;
    logic [slrf_pkg::ACC_W-1:0]         r_rem;
    logic [slrf_pkg::Q_W-1:0]           r_q;
    logic                               r_ovf;
    logic                               r_neg;

    logic [slrf_pkg::ACC_W-1:0]         num_mag;
    logic [slrf_pkg::ACC_W-1:0]         den_mag;
    logic [slrf_pkg::ACC_W:0]           trial;
    logic [slrf_pkg::ACC_W:0]           diff;
    logic                               take;
    logic                               sat_pos;
    logic                               sat_neg;

    // Operand magnitudes at start.
    assign num_mag = i_num[slrf_pkg::ACC_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[slrf_pkg::ACC_W-1] ? (~i_den + 1'b1) : i_den;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {r_rem, r_dvd[slrf_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, r_dm};
    assign take  = !diff[slrf_pkg::ACC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= slrf_pkg::DIV_CNT_W'(slrf_pkg::DVD_W - 1);
                r_dvd  <= {num_mag, {slrf_pkg::FRAC_W{1'b0}}};
                r_dm   <= den_mag;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_neg  <= i_num[slrf_pkg::ACC_W-1] ^ i_den[slrf_pkg::ACC_W-1];
            end else if (r_busy) begin
                r_rem <= take ? diff[slrf_pkg::ACC_W-1:0] : trial[slrf_pkg::ACC_W-1:0];
                r_q   <= {r_q[slrf_pkg::Q_W-2:0], take};
                r_ovf <= r_ovf | r_q[slrf_pkg::Q_W-1];
                r_dvd <= {r_dvd[slrf_pkg::DVD_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Sign, range check and clamp of the finished quotient.
    assign sat_pos = r_ovf || r_q[slrf_pkg::OUT_W] || r_q[slrf_pkg::OUT_W-1];
    assign sat_neg = r_ovf || r_q[slrf_pkg::OUT_W] ||
                     (r_q[slrf_pkg::OUT_W-1] && (r_q[slrf_pkg::OUT_W-2:0] != '0));

    always_comb begin
        if (r_neg) begin
            o_sat  = sat_neg;
            o_quot = sat_neg ? slrf_pkg::OUT_MIN : (~r_q[slrf_pkg::OUT_W-1:0] + 1'b1);
        end else begin
            o_sat  = sat_pos;
            o_quot = sat_pos ? slrf_pkg::OUT_MAX : r_q[slrf_pkg::OUT_W-1:0];
        end
    end

    assign o_done = r_fin;

endmodule

### src/slrf_dpath.sv
// Datapath of the line-fit unit: running sums, cross products, division and result register.
module slrf_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  slrf_pkg::t_ctrl_cmd     i_cmd,
    input  slrf_pkg::t_sample_req   i_sample,
    input  logic                    i_fit_stall,
    output slrf_pkg::t_dp_status    o_status,
    output logic                    o_fit_valid,
    output slrf_pkg::t_fit_req      o_fit
);

    // Running sums.
    logic [slrf_pkg::CNT_W-1:0]         r_count;
    logic signed [slrf_pkg::SUM_W-1:0]  r_sum_x;
    logic signed [slrf_pkg::SUM_W-1:0]  r_sum_y;
    logic signed [slrf_pkg::SQ_W-1:0]   r_sum_xx;
    logic signed [slrf_pkg::SQ_W-1:0]   r_sum_xy;
    logic                               r_dropped;

    logic signed [slrf_pkg::PROD1_W-1:0] xx;
    logic signed [slrf_pkg::PROD1_W-1:0] xy;
    logic                                set_full;

    assign xx       = i_sample.x_value * i_sample.x_value;
    assign xy       = i_sample.x_value * i_sample.y_value;
    assign set_full = (r_count == slrf_pkg::CNT_W'(slrf_pkg::MAX_SAMPLES));

    // Sum requests up to the set limit, flag any beyond; clear once the fit is handed over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_xx  <= '0;
            r_sum_xy  <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_count   <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_xx  <= '0;
            r_sum_xy  <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.sample_accept) begin
            if (set_full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count  <= r_count + 1'b1;
                r_sum_x  <= r_sum_x + {{(slrf_pkg::SUM_W-slrf_pkg::SAMPLE_W)
                            {i_sample.x_value[slrf_pkg::SAMPLE_W-1]}}, i_sample.x_value};
                r_sum_y  <= r_sum_y + {{(slrf_pkg::SUM_W-slrf_pkg::SAMPLE_W)
                            {i_sample.y_value[slrf_pkg::SAMPLE_W-1]}}, i_sample.y_value};
                r_sum_xx <= r_sum_xx + {{(slrf_pkg::SQ_W-slrf_pkg::PROD1_W)
                            {xx[slrf_pkg::PROD1_W-1]}}, xx};
                r_sum_xy <= r_sum_xy + {{(slrf_pkg::SQ_W-slrf_pkg::PROD1_W)
                            {xy[slrf_pkg::PROD1_W-1]}}, xy};
            end
        end
    end

    // Operand selection for the shared multiplier.
    logic [slrf_pkg::TERM_W-1:0]         term;
    logic                                half_hi;
    logic signed [slrf_pkg::SQ_W-1:0]    op_a;
    logic signed [slrf_pkg::SUM_W-1:0]   op_b;
    logic signed [slrf_pkg::HALF_W-1:0]  op_half;
    logic signed [slrf_pkg::PROD_W-1:0]  mul;
    logic signed [slrf_pkg::SQ_W-1:0]    sx_wide;
    logic signed [slrf_pkg::SUM_W-1:0]   n_wide;

    assign term    = i_cmd.mac_step[slrf_pkg::STEP_W-1:1];
    assign half_hi = i_cmd.mac_step[0];
    assign sx_wide = {{(slrf_pkg::SQ_W-slrf_pkg::SUM_W){r_sum_x[slrf_pkg::SUM_W-1]}}, r_sum_x};
    assign n_wide  = {{(slrf_pkg::SUM_W-slrf_pkg::CNT_W){1'b0}}, r_count};

    always_comb begin
        case (term)
            slrf_pkg::TERM_N_SXX: begin
                op_a = r_sum_xx;
                op_b = n_wide;
            end
            slrf_pkg::TERM_SX_SX: begin
                op_a = sx_wide;
                op_b = r_sum_x;
            end
            slrf_pkg::TERM_N_SXY: begin
                op_a = r_sum_xy;
                op_b = n_wide;
            end
            slrf_pkg::TERM_SX_SY: begin
                op_a = sx_wide;
                op_b = r_sum_y;
            end
            slrf_pkg::TERM_SY_SXX: begin
                op_a = r_sum_xx;
                op_b = r_sum_y;
            end
            slrf_pkg::TERM_SX_SXY: begin
                op_a = r_sum_xy;
                op_b = r_sum_x;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The wide operand is split into an unsigned low half and a signed high half.
    assign op_half = half_hi ?
        {{(slrf_pkg::HALF_W-slrf_pkg::A_HI_W){op_a[slrf_pkg::SQ_W-1]}},
         op_a[slrf_pkg::SQ_W-1:slrf_pkg::A_LO_W]} :
        {1'b0, op_a[slrf_pkg::A_LO_W-1:0]};
    assign mul = op_b * op_half;

    // Partial product register.
    logic signed [slrf_pkg::PROD_W-1:0]  r_prod;
    logic                                r_prod_valid;
    logic                                r_prod_hi;
    logic                                r_prod_sub;
    logic                                r_prod_end;
    logic [slrf_pkg::DEST_W-1:0]         r_prod_dest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_cmd.mac_valid;
        end
        r_prod      <= mul;
        r_prod_hi   <= half_hi;
        r_prod_sub  <= term[0];
        r_prod_end  <= term[0] && half_hi;
        r_prod_dest <= term[slrf_pkg::TERM_W-1:1];
    end

    // Accumulate term pairs into the denominator and the two numerators.
    logic signed [slrf_pkg::ACC_W-1:0]   r_acc;
    logic signed [slrf_pkg::ACC_W-1:0]   r_den;
    logic signed [slrf_pkg::ACC_W-1:0]   r_num_s;
    logic signed [slrf_pkg::ACC_W-1:0]   r_num_i;
    logic signed [slrf_pkg::ACC_W-1:0]   prod_ext;
    logic signed [slrf_pkg::ACC_W-1:0]   prod_aligned;
    logic signed [slrf_pkg::ACC_W-1:0]   acc_sum;

    assign prod_ext     = {{(slrf_pkg::ACC_W-slrf_pkg::PROD_W){r_prod[slrf_pkg::PROD_W-1]}},
                           r_prod};
    assign prod_aligned = r_prod_hi ? (prod_ext << slrf_pkg::A_LO_W) : prod_ext;
    assign acc_sum      = r_prod_sub ? (r_acc - prod_aligned) : (r_acc + prod_aligned);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_prod_valid) begin
            if (r_prod_end) begin
                r_acc <= '0;
            end else begin
                r_acc <= acc_sum;
            end
        end
        if (r_prod_valid && r_prod_end) begin
            case (r_prod_dest)
                slrf_pkg::DEST_DEN:   r_den   <= acc_sum;
                slrf_pkg::DEST_NUM_S: r_num_s <= acc_sum;
                slrf_pkg::DEST_NUM_I: r_num_i <= acc_sum;
                default:              r_num_i <= r_num_i;
            endcase
        end
    end

    // Shared divider for slope and intercept.
    logic                               div_done;
    logic [slrf_pkg::OUT_W-1:0]         div_quot;
    logic                               div_sat;
    logic                               r_div_icpt;
    logic [slrf_pkg::OUT_W-1:0]         r_slope;
    logic [slrf_pkg::OUT_W-1:0]         r_icpt;
    logic                               r_sat;

    slrf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (i_cmd.div_icpt ? r_num_i : r_num_s),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_sat   (div_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_sat <= 1'b0;
        end else if (div_done) begin
            r_sat <= r_sat | div_sat;
        end
        if (i_cmd.div_start) begin
            r_div_icpt <= i_cmd.div_icpt;
        end
        if (div_done) begin
            if (r_div_icpt) begin
                r_icpt <= div_quot;
            end else begin
                r_slope <= div_quot;
            end
        end
    end

    // Output register: holds the fit request until the receiver takes it.
    logic                   r_fit_valid;
    slrf_pkg::t_fit_req     r_fit;
    logic                   den_zero;

    assign den_zero = (r_den == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_fit_valid <= 1'b1;
        end else if (!i_fit_stall) begin
            r_fit_valid <= 1'b0;
        end
        if (i_cmd.load_result) begin
            if (den_zero) begin
                r_fit.slope      <= '0;
                r_fit.intercept  <= '0;
                r_fit.fit_status <= slrf_pkg::FIT_NO_SPREAD;
            end else begin
                r_fit.slope      <= r_slope;
                r_fit.intercept  <= r_icpt;
                r_fit.fit_status <= r_sat     ? slrf_pkg::FIT_SATURATED :
                                    r_dropped ? slrf_pkg::FIT_DROPPED : slrf_pkg::FIT_OK;
            end
        end
    end

    assign o_fit_valid       = r_fit_valid;
    assign o_fit             = r_fit;
    assign o_status.den_zero = den_zero;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_fit_valid || !i_fit_stall;

endmodule

### src/slrf_ctrl.sv
// Controller state machine of the line-fit unit.
module slrf_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_sample_valid,
    input  logic                    i_last,
    input  slrf_pkg::t_dp_status    i_status,
    output slrf_pkg::t_ctrl_cmd     o_cmd,
    output logic                    o_sample_stall
);

    localparam logic [2:0] ST_ACCUM  = 3'd0;
    localparam logic [2:0] ST_MAC    = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DIV_S  = 3'd3;
    localparam logic [2:0] ST_DIV_I  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [slrf_pkg::STEP_W-1:0]    r_step;
    logic [slrf_pkg::STEP_W-1:0]    n_step;
    logic                           accept;

    assign accept         = i_sample_valid && (r_state == ST_ACCUM);
    assign o_sample_stall = (r_state != ST_ACCUM);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ST_ACCUM: begin
                o_cmd.sample_accept = accept;
                if (accept && i_last) begin
                    n_state = ST_MAC;
                    n_step  = '0;
                end
            end
            ST_MAC: begin
                o_cmd.mac_valid = 1'b1;
                o_cmd.mac_step  = r_step;
                if (r_step == slrf_pkg::STEP_W'(slrf_pkg::NUM_STEPS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_status.den_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_S;
                end
            end
            ST_DIV_S: begin
                if (i_status.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_icpt  = 1'b1;
                    n_state         = ST_DIV_I;
                end
            end
            ST_DIV_I: begin
                if (i_status.div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = ST_ACCUM;
                end
            end
            default: begin
                n_state = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule
